// ===== rtl/hgnm_pkg.sv =====
// Package for the halo grid neighbor map: constants, register codes, pipeline types.
`default_nettype none
package hgnm_pkg;

  localparam int unsigned MAX_CELLS = 1024;
  localparam int unsigned MAX_GHOST = 4;

  localparam int unsigned CELLS_W = 11;
  localparam int unsigned FLAT_W  = 31;
  localparam int unsigned NBR_W   = 32;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned PLANE_W = 21;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned Q_W     = 11;   // quotient bits per divide

  // stage 0 captures, Q_W stages per divide, then the output register
  localparam int unsigned NSTAGE  = 1 + 2 * Q_W;
  localparam int unsigned LATENCY = NSTAGE + 1;

  // clamp, add, multiply, multiply
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  typedef enum logic [2:0] {
    REG_DIMENSIONS  = 3'd0,
    REG_CELLS_X     = 3'd1,
    REG_CELLS_Y     = 3'd2,
    REG_CELLS_Z     = 3'd3,
    REG_GHOST_WIDTH = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic              valid;
    logic              oor;
    logic [FLAT_W-1:0] flat;
    logic [FLAT_W-1:0] rem;
    logic [Q_W-1:0]    qk;
    logic [Q_W-1:0]    qj;
  } pipe_t;

  function automatic logic [CELLS_W-1:0] clamp_cells(input logic [CELLS_W-1:0] v);
    logic [CELLS_W-1:0] r;
    r = v;
    if (v == '0) r = CELLS_W'(1);
    else if (v > CELLS_W'(MAX_CELLS)) r = CELLS_W'(MAX_CELLS);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/halo_grid_neighbor_map.sv =====
// Halo grid neighbor map: pipelined decode of a padded-grid flat index.
//
// Usage: drive flat_index_i and pulse start; the item is taken at an edge
// where start is high and busy is low. One beat can enter every cycle while
// busy is low. Each result passes stage 0, the two divider chains and the
// output register, then appears on the output ports for one cycle with
// valid_o high, in input order. The receiver cannot stall; results are
// not held.
// The two divides (flat / plane, then remainder / row length) are restoring
// dividers unrolled into 11 register stages each, one quotient bit a stage;
// that chain sets the latency. Throughput is one item per non-busy cycle.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// writes are taken only while no item is in flight. After a write, and after
// reset, the clamped extents, padded extents, plane and total size are rebuilt
// in four register steps (clamp, add, multiply, multiply) and busy is high
// until they are done.
// Reset: asynchronous, active low; registers return to 3 axes, 64x64x64
// cells, 2 ghost layers; the pipeline empties.
`default_nettype none
module halo_grid_neighbor_map (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start,
  output logic                          busy,
  input  wire  [hgnm_pkg::FLAT_W-1:0]   flat_index_i,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [2:0]                    cfg_index_i,
  input  wire  [hgnm_pkg::CELLS_W-1:0]  cfg_data_i,
  output logic                          valid_o,
  output logic signed [11:0]            cell_i_o,
  output logic signed [11:0]            cell_j_o,
  output logic signed [11:0]            cell_k_o,
  output logic signed [31:0]            neighbor_x_low_o,
  output logic signed [31:0]            neighbor_x_high_o,
  output logic signed [31:0]            neighbor_y_low_o,
  output logic signed [31:0]            neighbor_y_high_o,
  output logic signed [31:0]            neighbor_z_low_o,
  output logic signed [31:0]            neighbor_z_high_o,
  output logic                          is_ghost_o,
  output logic                          index_out_of_range_o
);
  import hgnm_pkg::*;

  // raw registers
  logic [1:0]         dim_q;
  logic [CELLS_W-1:0] cx_q, cy_q, cz_q;
  logic [2:0]         gw_q;
  logic [2:0]         settle_q;

  // derived geometry
  logic               use_y_q, use_z_q;
  logic [CELLS_W-1:0] nx_q, ny_q, nz_q;
  logic [3:0]         gx_q, gy_q, gz_q;
  logic [CELLS_W-1:0] tx_q, ty_q, tz_q;
  logic [PLANE_W-1:0] plane_q;
  logic [TOTAL_W-1:0] total_q;

  // divider pipeline
  pipe_t pipe_d [NSTAGE];
  pipe_t pipe_q [NSTAGE];

  logic cfg_we;
  logic inflight;

  always_comb begin
    inflight = 1'b0;
    for (int s = 0; s < NSTAGE; s++) inflight = inflight | pipe_q[s].valid;
  end

  assign busy        = (settle_q != '0);
  assign cfg_ready_o = !inflight && !(start && !busy);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= 2'd3;
      cx_q     <= CELLS_W'(64);
      cy_q     <= CELLS_W'(64);
      cz_q     <= CELLS_W'(64);
      gw_q     <= 3'd2;
      settle_q <= SETTLE_CYCLES;
    end else begin
      if (cfg_we) begin
        settle_q <= SETTLE_CYCLES;
        case (cfg_index_i)
          REG_DIMENSIONS:  dim_q <= cfg_data_i[1:0];
          REG_CELLS_X:     cx_q  <= cfg_data_i;
          REG_CELLS_Y:     cy_q  <= cfg_data_i;
          REG_CELLS_Z:     cz_q  <= cfg_data_i;
          REG_GHOST_WIDTH: gw_q  <= cfg_data_i[2:0];
          default: ;
        endcase
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 3'd1;
      end
    end
  end

  // geometry rebuild: extents, then plane, then total
  logic [3:0] g_sat;
  assign g_sat = (gw_q > 3'(MAX_GHOST)) ? 4'(MAX_GHOST) : {1'b0, gw_q};

  always_ff @(posedge clk_i) begin
    use_y_q <= (dim_q >= 2'd2);
    use_z_q <= (dim_q == 2'd3);
    nx_q    <= clamp_cells(cx_q);
    ny_q    <= (dim_q >= 2'd2) ? clamp_cells(cy_q) : CELLS_W'(1);
    nz_q    <= (dim_q == 2'd3) ? clamp_cells(cz_q) : CELLS_W'(1);
    gx_q    <= g_sat;
    gy_q    <= (dim_q >= 2'd2) ? g_sat : 4'd0;
    gz_q    <= (dim_q == 2'd3) ? g_sat : 4'd0;
    tx_q    <= nx_q + CELLS_W'({gx_q, 1'b0});
    ty_q    <= ny_q + CELLS_W'({gy_q, 1'b0});
    tz_q    <= nz_q + CELLS_W'({gz_q, 1'b0});
    plane_q <= PLANE_W'(tx_q * ty_q);
    total_q <= TOTAL_W'(plane_q * tz_q);
  end

  always_comb begin
    pipe_d[0].valid = start && !busy;
    pipe_d[0].oor   = {1'b0, flat_index_i} >= total_q;
    pipe_d[0].flat  = flat_index_i;
    pipe_d[0].rem   = flat_index_i;
    pipe_d[0].qk    = '0;
    pipe_d[0].qj    = '0;
  end

  for (genvar s = 1; s <= Q_W; s++) begin : g_kdiv
    localparam int unsigned B = Q_W - s;
    logic [31:0] dv, ext;
    logic        ge;
    assign dv  = 32'(plane_q) << B;
    assign ext = {1'b0, pipe_q[s-1].rem};
    assign ge  = ext >= dv;
    always_comb begin
      pipe_d[s]       = pipe_q[s-1];
      pipe_d[s].rem   = ge ? FLAT_W'(ext - dv) : pipe_q[s-1].rem;
      pipe_d[s].qk[B] = ge;
    end
  end

  for (genvar s = Q_W + 1; s < NSTAGE; s++) begin : g_jdiv
    localparam int unsigned B = 2 * Q_W - s;
    logic [31:0] dv, ext;
    logic        ge;
    assign dv  = 32'(tx_q) << B;
    assign ext = {1'b0, pipe_q[s-1].rem};
    assign ge  = ext >= dv;
    always_comb begin
      pipe_d[s]       = pipe_q[s-1];
      pipe_d[s].rem   = ge ? FLAT_W'(ext - dv) : pipe_q[s-1].rem;
      pipe_d[s].qj[B] = ge;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NSTAGE; s++) pipe_q[s] <= '0;
    end else begin
      for (int s = 0; s < NSTAGE; s++) pipe_q[s] <= pipe_d[s];
    end
  end

  // output stage
  pipe_t       last;
  logic [11:0] pi, pj, pk;
  logic [31:0] fl;
  logic        ghost_d;
  assign last = pipe_q[NSTAGE-1];
  assign pi   = 12'(last.rem);
  assign pj   = 12'(last.qj);
  assign pk   = 12'(last.qk);
  assign fl   = {1'b0, last.flat};

  always_comb begin
    ghost_d = (pi < 12'(gx_q)) || (pi >= 12'(nx_q) + 12'(gx_q));
    if (use_y_q && ((pj < 12'(gy_q)) || (pj >= 12'(ny_q) + 12'(gy_q)))) ghost_d = 1'b1;
    if (use_z_q && ((pk < 12'(gz_q)) || (pk >= 12'(nz_q) + 12'(gz_q)))) ghost_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.oor) begin
      cell_i_o             <= '0;
      cell_j_o             <= '0;
      cell_k_o             <= '0;
      neighbor_x_low_o     <= '1;
      neighbor_x_high_o    <= '1;
      neighbor_y_low_o     <= '1;
      neighbor_y_high_o    <= '1;
      neighbor_z_low_o     <= '1;
      neighbor_z_high_o    <= '1;
      is_ghost_o           <= 1'b0;
      index_out_of_range_o <= 1'b1;
    end else begin
      cell_i_o          <= pi - 12'(gx_q);
      cell_j_o          <= pj - 12'(gy_q);
      cell_k_o          <= pk - 12'(gz_q);
      neighbor_x_low_o  <= (pi != '0) ? fl - 32'd1 : '1;
      neighbor_x_high_o <= (pi + 12'd1 < 12'(tx_q)) ? fl + 32'd1 : '1;
      neighbor_y_low_o  <= (use_y_q && pj != '0) ? fl - 32'(tx_q) : '1;
      neighbor_y_high_o <= (use_y_q && (pj + 12'd1 < 12'(ty_q))) ? fl + 32'(tx_q) : '1;
      neighbor_z_low_o  <= (use_z_q && pk != '0) ? fl - 32'(plane_q) : '1;
      neighbor_z_high_o <= (use_z_q && (pk + 12'd1 < 12'(tz_q))) ? fl + 32'(plane_q) : '1;
      is_ghost_o           <= ghost_d;
      index_out_of_range_o <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hgnm_checker.sv =====
// Port-level checker for the halo grid neighbor map, bound to the top level.
`default_nettype none
module hgnm_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               start,
  input wire               busy,
  input wire               valid_o,
  input wire signed [11:0] cell_i_o,
  input wire signed [31:0] neighbor_x_low_o,
  input wire signed [31:0] neighbor_z_high_o,
  input wire               is_ghost_o,
  input wire               index_out_of_range_o
);
  import hgnm_pkg::*;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY valid_o)
    else $error("accepted beat gave no result at expected latency");

  a_oor_not_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(index_out_of_range_o && is_ghost_o))
    else $error("out of range index flagged as ghost");

  a_oor_nbrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && index_out_of_range_o) |->
      (neighbor_x_low_o == -32'sd1 && neighbor_z_high_o == -32'sd1))
    else $error("out of range index produced neighbors");

  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !is_ghost_o && !index_out_of_range_o) |-> (cell_i_o >= 12'sd0))
    else $error("interior cell with negative coordinate");

endmodule

bind halo_grid_neighbor_map hgnm_checker u_hgnm_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for halo_grid_neighbor_map: predicts each decode and checks it.
`timescale 1ns / 100ps
module tb;
  import hgnm_pkg::*;

  localparam logic [2:0] REG_UNMAPPED = 3'd5;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [31:0] NO_NBR = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [11:0] ci, cj, ck;
    logic [31:0] xl, xh, yl, yh, zl, zh;
    logic        ghost, oor;
  } decode_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [FLAT_W-1:0] flat_index_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [CELLS_W-1:0] cfg_data_i = '0;
  logic busy, cfg_ready_o, valid_o, is_ghost_o, index_out_of_range_o;
  logic signed [11:0] cell_i_o, cell_j_o, cell_k_o;
  logic signed [31:0] neighbor_x_low_o, neighbor_x_high_o, neighbor_y_low_o;
  logic signed [31:0] neighbor_y_high_o, neighbor_z_low_o, neighbor_z_high_o;

  halo_grid_neighbor_map DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow registers
  logic [1:0]  sh_dims = 2'd3;
  logic [10:0] sh_cx = 11'd64, sh_cy = 11'd64, sh_cz = 11'd64;
  logic [2:0]  sh_gw = 3'd2;

  decode_t pending_decodes[$];
  int errors = 0, items_sent = 0, results_seen = 0, ghost_hits = 0, oor_hits = 0;
  int configs_written = 0, idle_cycles = 0;
  bit gaps_on = 1'b1;

  function automatic longint unsigned eff_cells(logic [10:0] v);
    if (v == 0) return 1;
    if (v > MAX_CELLS) return MAX_CELLS;
    return v;
  endfunction

  // padded array size under the current settings
  function automatic longint unsigned padded_total();
    longint unsigned d, g, nx, ny, nz;
    d = (sh_dims == 0) ? 1 : sh_dims;
    g = (sh_gw > MAX_GHOST) ? MAX_GHOST : sh_gw;
    nx = eff_cells(sh_cx) + 2 * g;
    ny = (d >= 2) ? eff_cells(sh_cy) + 2 * g : 1;
    nz = (d >= 3) ? eff_cells(sh_cz) + 2 * g : 1;
    return nx * ny * nz;
  endfunction

  function automatic decode_t decode_index(logic [30:0] flat_in);
    decode_t r;
    longint unsigned d, g, gy, gz, nx, ny, nz, tx, ty, tz, plane, total, f;
    longint unsigned pi, pj, pk, rem;
    d = (sh_dims == 0) ? 1 : sh_dims;
    g = (sh_gw > MAX_GHOST) ? MAX_GHOST : sh_gw;
    nx = eff_cells(sh_cx);
    ny = (d >= 2) ? eff_cells(sh_cy) : 1;
    nz = (d >= 3) ? eff_cells(sh_cz) : 1;
    gy = (d >= 2) ? g : 0;
    gz = (d >= 3) ? g : 0;
    tx = nx + 2 * g;
    ty = ny + 2 * gy;
    tz = nz + 2 * gz;
    plane = tx * ty;
    total = plane * tz;
    f = flat_in;
    r = '0;
    {r.xl, r.xh, r.yl, r.yh, r.zl, r.zh} = {6{NO_NBR}};
    if (f >= total) begin
      r.oor = 1'b1;
      return r;
    end
    pk = f / plane;
    rem = f - pk * plane;
    pj = rem / tx;
    pi = rem - pj * tx;
    r.ci = 12'(pi - g);
    r.cj = 12'(pj - gy);
    r.ck = 12'(pk - gz);
    if (pi > 0) r.xl = 32'(f - 1);
    if (pi + 1 < tx) r.xh = 32'(f + 1);
    if (d >= 2) begin
      if (pj > 0) r.yl = 32'(f - tx);
      if (pj + 1 < ty) r.yh = 32'(f + tx);
    end
    if (d >= 3) begin
      if (pk > 0) r.zl = 32'(f - plane);
      if (pk + 1 < tz) r.zh = 32'(f + plane);
    end
    r.ghost = (pi < g) || (pi >= nx + g) ||
              (d >= 2 && (pj < gy || pj >= ny + gy)) ||
              (d >= 3 && (pk < gz || pk >= nz + gz));
    return r;
  endfunction

  task automatic gap();
    int n;
    n = $urandom_range(1, 7);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_index(logic [30:0] v);
    decode_t e;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap();
    end
    start <= 1'b1;
    flat_index_i <= v;
    do @(posedge clk_i); while (busy);
    e = decode_index(v);
    pending_decodes = {pending_decodes, e};
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [10:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_DIMENSIONS:  sh_dims = data[1:0];
      REG_CELLS_X:     sh_cx = data;
      REG_CELLS_Y:     sh_cy = data;
      REG_CELLS_Z:     sh_cz = data;
      REG_GHOST_WIDTH: sh_gw = data[2:0];
      default: ;
    endcase
    configs_written++;
    @(posedge clk_i);
  endtask

  task automatic set_grid(logic [1:0] d, logic [10:0] x, logic [10:0] y,
                          logic [10:0] z, logic [2:0] g);
    drain();
    write_reg(REG_DIMENSIONS, 11'(d));
    write_reg(REG_CELLS_X, x);
    write_reg(REG_CELLS_Y, y);
    write_reg(REG_CELLS_Z, z);
    write_reg(REG_GHOST_WIDTH, 11'(g));
  endtask

  // corners, first interior cell, last slot, just past the end, top of range
  task automatic send_edges();
    longint unsigned t, g, tx, ty;
    t = padded_total();
    g = (sh_gw > MAX_GHOST) ? MAX_GHOST : sh_gw;
    tx = eff_cells(sh_cx) + 2 * g;
    ty = (sh_dims >= 2) ? eff_cells(sh_cy) + 2 * g : 1;
    send_index(31'd0);
    send_index(31'((g * (1 + tx + tx * ty)) % t));
    send_index(31'(t - 1));
    send_index(31'(t));
    send_index({31{1'b1}});
  endtask

  task automatic test_reset_defaults();
    send_edges();
  endtask

  task automatic test_register_clamps();
    // zero cells act as one, oversize cells and ghost width saturate
    set_grid(2'd2, 11'd0, 11'd2047, 11'd5, 3'd7);
    send_edges();
    // zero dimensions act as one axis; y and z ignored
    set_grid(2'd0, 11'd1024, 11'd9, 11'd9, 3'd4);
    send_edges();
  endtask

  task automatic test_smallest_and_largest();
    set_grid(2'd3, 11'd1, 11'd1, 11'd1, 3'd0);
    send_index(31'd0);
    send_index(31'd1);
    set_grid(2'd3, 11'd1024, 11'd1024, 11'd1024, 3'd4);
    send_edges();
    // a write to an unmapped index must change nothing
    drain();
    write_reg(REG_UNMAPPED, 11'h7FF);
    send_edges();
  endtask

  task automatic test_random(int phases, int per_phase);
    longint unsigned t;
    int sel;
    logic [10:0] cx, cy, cz;
    for (int p = 0; p < phases; p++) begin
      // mostly small grids, now and then full-range register values
      cx = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047)) :
           11'($urandom_range(1, 40));
      cy = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047)) :
           11'($urandom_range(1, 40));
      cz = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047)) :
           11'($urandom_range(1, 40));
      if (p == phases - 1) gaps_on = 1'b0;
      set_grid(2'($urandom_range(0, 3)), cx, cy, cz, 3'($urandom_range(0, 7)));
      t = padded_total();
      for (int n = 0; n < per_phase; n++) begin
        sel = $urandom_range(0, 19);
        if (sel == 0)
          send_index(31'($urandom()));
        else if (sel == 1)
          send_index(31'(t + $urandom_range(0, 64)));
        else
          send_index(31'($urandom_range(0, 32'(t - 1))));
      end
    end
  endtask

  task automatic cmp(string fname, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0h got %0h (result %0d)",
                 fname, e, a, results_seen);
    end
  endtask

  always @(posedge clk_i) begin
    decode_t e;
    if (rst_ni && valid_o) begin
      if (pending_decodes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing expected");
      end else begin
        e = pending_decodes.pop_front();
        cmp("cell_i", 32'($signed(e.ci)), 32'(cell_i_o));
        cmp("cell_j", 32'($signed(e.cj)), 32'(cell_j_o));
        cmp("cell_k", 32'($signed(e.ck)), 32'(cell_k_o));
        cmp("neighbor_x_low", e.xl, neighbor_x_low_o);
        cmp("neighbor_x_high", e.xh, neighbor_x_high_o);
        cmp("neighbor_y_low", e.yl, neighbor_y_low_o);
        cmp("neighbor_y_high", e.yh, neighbor_y_high_o);
        cmp("neighbor_z_low", e.zl, neighbor_z_low_o);
        cmp("neighbor_z_high", e.zh, neighbor_z_high_o);
        cmp("is_ghost", 32'(e.ghost), 32'(is_ghost_o));
        cmp("index_out_of_range", 32'(e.oor), 32'(index_out_of_range_o));
        ghost_hits += e.ghost;
        oor_hits += e.oor;
      end
      results_seen++;
    end
  end

  // watchdog: cycles with no beat of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding",
               pending_decodes.size());
      $display("** halo_grid_neighbor_map: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_register_clamps();
    test_smallest_and_largest();
    test_random(8, 250);
    drain();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (pending_decodes.size() != 0) errors++;
    $display("%0d indices sent, %0d decoded, %0d ghost cells, %0d out of range",
             items_sent, results_seen, ghost_hits, oor_hits);
    $display("%0d register writes, %0d mismatches", configs_written, errors);
    if (errors == 0)
      $display("** halo_grid_neighbor_map: PASSED **");
    else
      $display("** halo_grid_neighbor_map: FAILED **");
    $finish;
  end
endmodule
